// ===== hw/rtl/hall_pair_rotor_angle_defines.svh =====
// ----------------------------------------------------------------------------
// hall_pair_rotor_angle_defines.svh
// Assertion macros shared by the rotor angle decoder RTL.
// ----------------------------------------------------------------------------
`ifndef HALL_PAIR_ROTOR_ANGLE_DEFINES_SVH
`define HALL_PAIR_ROTOR_ANGLE_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising edge outside reset.
`define HPRA_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define HPRA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define HPRA_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons)
`define HPRA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

// ===== hw/rtl/hpra_pkg.sv =====
// ----------------------------------------------------------------------------
// hpra_pkg
// Types, constants and the arcsine table of the rotor angle decoder.
// ----------------------------------------------------------------------------
package hpra_pkg;

    localparam int SAMPLE_W = 10;
    localparam int GAIN_W   = 26;
    localparam int ANGLE_W  = 12;
    localparam int CFG_W    = 26;
    localparam int CFG_IDX_W = 2;
    localparam int ROM_W    = 10;
    localparam int IDX_W    = 9;
    localparam int PROD_W   = SAMPLE_W + GAIN_W;
    localparam int SHIFT    = 16;

    localparam logic [IDX_W-1:0]   INDEX_MAX  = 9'd256;
    localparam logic [ANGLE_W-1:0] ANGLE_HALF = 12'd1024;
    localparam logic [ANGLE_W-1:0] ANGLE_FULL = 12'd2048;

    localparam logic [SAMPLE_W-1:0] MEDIAN_RST = 10'd512;
    localparam logic [GAIN_W-1:0]   GAIN_RST   = 26'd65536;
    localparam logic [SAMPLE_W-1:0] SPLIT_RST  = 10'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRIMARY_MEDIAN  = 2'd0,
        REG_PRIMARY_GAIN    = 2'd1,
        REG_UPPER_SPLIT     = 2'd2,
        REG_LOWER_SPLIT     = 2'd3
    } hpra_reg_idx_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] primary_median;
        logic [GAIN_W-1:0]   primary_gain;
        logic [SAMPLE_W-1:0] secondary_upper_split;
        logic [SAMPLE_W-1:0] secondary_lower_split;
    } hpra_cfg_t;

    // Quarter-turn arcsine, 512 = quarter turn, indexed by scaled magnitude.
    localparam logic [ROM_W-1:0] ARCSINE_ROM [0:256] = '{
        10'd0, 10'd1, 10'd3, 10'd4, 10'd5, 10'd6, 10'd8, 10'd9, 10'd10, 10'd11,
        10'd13, 10'd14, 10'd15, 10'd17, 10'd18, 10'd19, 10'd20, 10'd22, 10'd23, 10'd24,
        10'd25, 10'd27, 10'd28, 10'd29, 10'd31, 10'd32, 10'd33, 10'd34, 10'd36, 10'd37,
        10'd38, 10'd40, 10'd41, 10'd42, 10'd43, 10'd45, 10'd46, 10'd47, 10'd49, 10'd50,
        10'd51, 10'd52, 10'd54, 10'd55, 10'd56, 10'd58, 10'd59, 10'd60, 10'd61, 10'd63,
        10'd64, 10'd65, 10'd67, 10'd68, 10'd69, 10'd71, 10'd72, 10'd73, 10'd74, 10'd76,
        10'd77, 10'd78, 10'd80, 10'd81, 10'd82, 10'd84, 10'd85, 10'd86, 10'd88, 10'd89,
        10'd90, 10'd92, 10'd93, 10'd94, 10'd96, 10'd97, 10'd98, 10'd100, 10'd101, 10'd102,
        10'd104, 10'd105, 10'd106, 10'd108, 10'd109, 10'd110, 10'd112, 10'd113, 10'd114,
        10'd116, 10'd117, 10'd118, 10'd120, 10'd121, 10'd123, 10'd124, 10'd125, 10'd127,
        10'd128, 10'd129,
        10'd131, 10'd132, 10'd134, 10'd135, 10'd136, 10'd138, 10'd139, 10'd141, 10'd142,
        10'd143, 10'd145, 10'd146, 10'd148, 10'd149, 10'd150, 10'd152, 10'd153, 10'd155,
        10'd156, 10'd158,
        10'd159, 10'd160, 10'd162, 10'd163, 10'd165, 10'd166, 10'd168, 10'd169, 10'd171,
        10'd172, 10'd174, 10'd175, 10'd177, 10'd178, 10'd180, 10'd181, 10'd183, 10'd184,
        10'd186, 10'd187,
        10'd189, 10'd190, 10'd192, 10'd193, 10'd195, 10'd196, 10'd198, 10'd199, 10'd201,
        10'd202, 10'd204, 10'd206, 10'd207, 10'd209, 10'd210, 10'd212, 10'd214, 10'd215,
        10'd217, 10'd218,
        10'd220, 10'd222, 10'd223, 10'd225, 10'd227, 10'd228, 10'd230, 10'd232, 10'd233,
        10'd235, 10'd237, 10'd238, 10'd240, 10'd242, 10'd244, 10'd245, 10'd247, 10'd249,
        10'd251, 10'd252,
        10'd254, 10'd256, 10'd258, 10'd260, 10'd261, 10'd263, 10'd265, 10'd267, 10'd269,
        10'd271, 10'd273, 10'd275, 10'd276, 10'd278, 10'd280, 10'd282, 10'd284, 10'd286,
        10'd288, 10'd290,
        10'd292, 10'd294, 10'd296, 10'd298, 10'd301, 10'd303, 10'd305, 10'd307, 10'd309,
        10'd311, 10'd314, 10'd316, 10'd318, 10'd320, 10'd323, 10'd325, 10'd327, 10'd330,
        10'd332, 10'd335,
        10'd337, 10'd340, 10'd342, 10'd345, 10'd347, 10'd350, 10'd353, 10'd355, 10'd358,
        10'd361, 10'd364, 10'd367, 10'd370, 10'd373, 10'd376, 10'd379, 10'd382, 10'd386,
        10'd389, 10'd393,
        10'd396, 10'd400, 10'd404, 10'd408, 10'd412, 10'd416, 10'd421, 10'd425, 10'd430,
        10'd436, 10'd441, 10'd447, 10'd454, 10'd462, 10'd471, 10'd483, 10'd512
    };

    // Indexes above the table end never occur after saturation; clamp anyway.
    function automatic logic [ROM_W-1:0] arcsine_lookup(input logic [IDX_W-1:0] idx);
        logic [ROM_W-1:0] val;
        if (idx > INDEX_MAX)
        begin
            val = ARCSINE_ROM[256];
        end
        else
        begin
            val = ARCSINE_ROM[idx];
        end
        return val;
    endfunction

endpackage

// ===== hw/rtl/hpra_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// hpra_cfg_regs
// Calibration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module hpra_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [hpra_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hpra_pkg::CFG_W-1:0]        cfg_data,
    output hpra_pkg::hpra_cfg_t               cfg
);
    import hpra_pkg::*;

    hpra_cfg_t cfg_reg;
    hpra_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (hpra_reg_idx_t'(cfg_index))
                REG_PRIMARY_MEDIAN: cfg_next.primary_median        = cfg_data[SAMPLE_W-1:0];
                REG_PRIMARY_GAIN:   cfg_next.primary_gain          = cfg_data[GAIN_W-1:0];
                REG_UPPER_SPLIT:    cfg_next.secondary_upper_split = cfg_data[SAMPLE_W-1:0];
                REG_LOWER_SPLIT:    cfg_next.secondary_lower_split = cfg_data[SAMPLE_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.primary_median        <= MEDIAN_RST;
            cfg_reg.primary_gain          <= GAIN_RST;
            cfg_reg.secondary_upper_split <= SPLIT_RST;
            cfg_reg.secondary_lower_split <= SPLIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/hpra_angle_calc.sv =====
// ----------------------------------------------------------------------------
// hpra_angle_calc
// Offset, scaled magnitude, arcsine lookup and quadrant selection.
// ----------------------------------------------------------------------------
module hpra_angle_calc (
    input  hpra_pkg::hpra_cfg_t                cfg,
    input  logic [hpra_pkg::SAMPLE_W-1:0]      primary_sample,
    input  logic [hpra_pkg::SAMPLE_W-1:0]      secondary_sample,
    output logic [hpra_pkg::ANGLE_W-1:0]       angle
);
    import hpra_pkg::*;

    logic [SAMPLE_W:0]       diff;
    logic [SAMPLE_W:0]       mag_full;
    logic [SAMPLE_W-1:0]     mag;
    logic                    is_neg;
    logic                    is_pos;
    logic [PROD_W-1:0]       prod;
    logic [PROD_W-SHIFT-1:0] scaled;
    logic [IDX_W-1:0]        idx;
    logic [ROM_W-1:0]        rom_val;
    logic [ANGLE_W-1:0]      rom_ext;

    always_comb
    begin
        diff     = {1'b0, primary_sample} - {1'b0, cfg.primary_median};
        is_neg   = diff[SAMPLE_W];
        is_pos   = !is_neg && (diff != '0);
        mag_full = is_neg ? ((SAMPLE_W+1)'(0) - diff) : diff;
        mag      = mag_full[SAMPLE_W-1:0];

        // Full-width product, so a large gain saturates instead of wrapping.
        prod   = PROD_W'(mag) * PROD_W'(cfg.primary_gain);
        scaled = prod[PROD_W-1:SHIFT];
        if (scaled > (PROD_W-SHIFT)'(INDEX_MAX))
        begin
            idx = INDEX_MAX;
        end
        else
        begin
            idx = scaled[IDX_W-1:0];
        end

        rom_val = arcsine_lookup(idx);
        rom_ext = ANGLE_W'(rom_val);

        // Sign picks half, second sensor quarter; zero offset lands on full turn.
        if (is_pos && (secondary_sample <= cfg.secondary_upper_split))
        begin
            angle = rom_ext;
        end
        else if (is_pos)
        begin
            angle = ANGLE_HALF - rom_ext;
        end
        else if (is_neg && (secondary_sample > cfg.secondary_lower_split))
        begin
            angle = ANGLE_HALF + rom_ext;
        end
        else
        begin
            angle = ANGLE_FULL - rom_ext;
        end
    end

endmodule

// ===== hw/rtl/hall_pair_rotor_angle.sv =====
// ----------------------------------------------------------------------------
// hall_pair_rotor_angle
// Rotor angle decoder for a pair of linear Hall sensors (2048 = full turn).
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+-------------------------------------
//  input    | in_valid / in_stall    | primary_sample, secondary_sample
//  output   | out_valid / out_stall  | rotor_angle
//  config   | cfg_write              | cfg_index, cfg_data
//
//  One pair per cycle unless the output stalls; the sample register holds
//  each pair and the result register its angle. Subtract, 10x26 multiply,
//  arcsine table and quadrant add between the two registers set the cycle.
//  Reset loads the calibration defaults and empties both stages at once.
//  A stalled result holds; the input stalls only when both stages are full
//  and the output is stalled.
//
`include "hall_pair_rotor_angle_defines.svh"

module hall_pair_rotor_angle (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [hpra_pkg::SAMPLE_W-1:0]     primary_sample,
    input  logic [hpra_pkg::SAMPLE_W-1:0]     secondary_sample,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [hpra_pkg::ANGLE_W-1:0]      rotor_angle,
    input  logic                              cfg_write,
    input  logic [hpra_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hpra_pkg::CFG_W-1:0]        cfg_data
);
    import hpra_pkg::*;

    hpra_cfg_t            cfg;

    // Sample stage
    logic                 in_vld_reg;
    logic                 in_vld_next;
    logic [SAMPLE_W-1:0]  prim_reg;
    logic [SAMPLE_W-1:0]  sec_reg;

    // Result stage
    logic                 out_vld_reg;
    logic                 out_vld_next;
    logic [ANGLE_W-1:0]   angle_reg;
    logic [ANGLE_W-1:0]   angle_calc;

    logic                 out_free;
    logic                 in_take;

    hpra_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hpra_angle_calc u_calc (
        .cfg              (cfg),
        .primary_sample   (prim_reg),
        .secondary_sample (sec_reg),
        .angle            (angle_calc)
    );

    // Result register frees when empty or when its result transfers this cycle.
    assign out_free = !out_vld_reg || !out_stall;
    // Sample register can take a new pair unless its contents are stuck.
    assign in_stall = in_vld_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next  = in_vld_reg;
        out_vld_next = out_vld_reg;
        if (!in_stall)
        begin
            in_vld_next = in_valid;
        end
        if (out_free)
        begin
            out_vld_next = in_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Capture the sample pair on transfer; hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            prim_reg <= primary_sample;
            sec_reg  <= secondary_sample;
        end
    end

    // Advance the computed angle into the result register.
    always_ff @(posedge clk)
    begin
        if (out_free && in_vld_reg)
        begin
            angle_reg <= angle_calc;
        end
    end

    assign out_valid   = out_vld_reg;
    assign rotor_angle = angle_reg;

    `HPRA_ASSERT_IMPL(a_angle_range, clk, rst_n, out_valid, rotor_angle <= ANGLE_FULL)
    `HPRA_ASSERT_NEXT(a_in_loads, clk, rst_n, in_valid && !in_stall, in_vld_reg)
    `HPRA_ASSERT_NEXT(a_stage_moves, clk, rst_n, in_vld_reg && out_free, out_valid)
    `HPRA_ASSERT_NEXT(a_gain_write, clk, rst_n,
        cfg_write && (cfg_index == REG_PRIMARY_GAIN),
        cfg.primary_gain == $past(cfg_data[GAIN_W-1:0]))

endmodule
